// File: hw/rtl/efbr_pkg.sv
// Shared types, widths and the microcode table of the ECG filter and beat-rate core.
// Depends on nothing; imported by efbr_seq and ecg_filter_beat_rate_core.
package efbr_pkg;

    localparam int AVG_LOG2 = 3;
    localparam int AVG_LEN  = 1 << AVG_LOG2;
    localparam int TAPS     = 4;

    localparam int SAMPLE_W = 10;
    localparam int SLOT_W   = AVG_LOG2;
    localparam int SUM_W    = SAMPLE_W + AVG_LOG2;
    localparam int NOTCH_W  = SAMPLE_W + 1;
    localparam int LOW_W    = 15;
    localparam int CNT_W    = 16;
    localparam int DIV_CNT_W = $clog2(CNT_W);

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REFRACTORY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_NUMERATOR  = 2'd2;

    localparam logic [LOW_W-1:0] THRESHOLD_RST  = 15'd800;
    localparam logic [CNT_W-1:0] REFRACTORY_RST = 16'd80;
    localparam logic [CNT_W-1:0] NUMERATOR_RST  = 16'd28800;
    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_LOAD  = 3'd1,
        OP_RING  = 3'd2,
        OP_NOTCH = 3'd3,
        OP_LOW   = 3'd4,
        OP_TEST  = 3'd5,
        OP_DIV   = 3'd6,
        OP_EMIT  = 3'd7
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_WAIT_IN  = 3'd1,
        C_NOBEAT   = 3'd2,
        C_LOOP     = 3'd3,
        C_WAIT_OUT = 3'd4,
        C_JUMP     = 3'd5
    } jcond_t;

    typedef struct packed {
        uop_t   op;
        jcond_t cond;
        step_t  target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic beat;
        logic div_last;
        logic out_free;
    } efbr_cond_t;

    localparam step_t STEP_FETCH = 3'd0;
    localparam step_t STEP_RING  = 3'd1;
    localparam step_t STEP_NOTCH = 3'd2;
    localparam step_t STEP_LOW   = 3'd3;
    localparam step_t STEP_TEST  = 3'd4;
    localparam step_t STEP_DIV   = 3'd5;
    localparam step_t STEP_EMIT  = 3'd6;

    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        w = '{op: OP_NOP, cond: C_JUMP, target: STEP_FETCH};
        unique case (pc)
            STEP_FETCH: w = '{op: OP_LOAD,  cond: C_WAIT_IN,  target: STEP_RING};
            STEP_RING:  w = '{op: OP_RING,  cond: C_NEXT,     target: STEP_FETCH};
            STEP_NOTCH: w = '{op: OP_NOTCH, cond: C_NEXT,     target: STEP_FETCH};
            STEP_LOW:   w = '{op: OP_LOW,   cond: C_NEXT,     target: STEP_FETCH};
            STEP_TEST:  w = '{op: OP_TEST,  cond: C_NOBEAT,   target: STEP_EMIT};
            STEP_DIV:   w = '{op: OP_DIV,   cond: C_LOOP,     target: STEP_FETCH};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_WAIT_OUT, target: STEP_FETCH};
            default:    w = '{op: OP_NOP,   cond: C_JUMP,     target: STEP_FETCH};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/efbr_seq.sv
// Microcode sequencer: step counter, control-word table and conditional jumps.
// Depends on efbr_pkg.
module efbr_seq
    import efbr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  efbr_cond_t cond,
    output uop_t       op
);

    step_t  pc_reg, pc_next;
    uword_t word;

    assign word = ucode(pc_reg);
    assign op   = word.op;

    always_comb begin
        pc_next = pc_reg;
        unique case (word.cond)
            C_NEXT:     pc_next = pc_reg + 1'b1;
            C_WAIT_IN:  pc_next = cond.in_valid ? word.target : pc_reg;
            C_NOBEAT:   pc_next = cond.beat ? pc_reg + 1'b1 : word.target;
            C_LOOP:     pc_next = cond.div_last ? pc_reg + 1'b1 : pc_reg;
            C_WAIT_OUT: pc_next = cond.out_free ? word.target : pc_reg;
            C_JUMP:     pc_next = word.target;
            default:    pc_next = STEP_FETCH;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: hw/rtl/ecg_filter_beat_rate_core.sv
// ECG conditioning and beat-rate core: 8-sample mean, notch, 1-4-6-4-1 lowpass, beat detect.
// Depends on efbr_pkg and efbr_seq.
//
// One sample in, one result beat out. A short microprogram walks each sample through a
// running-sum mean, the four-back notch, the binomial lowpass and the beat test; a sample
// with a beat also passes through the one-bit-per-cycle restoring divider that forms the
// rate. The next sample is taken once the result sits in the output
// register, so a stalled consumer holds the block only when a second result is ready.
// Configuration writes land at once and should be made between samples.
module ecg_filter_beat_rate_core
    import efbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [9:0] sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] averaged, [24:10] filtered, [40:25] rate_bpm
    output logic                  m_tuser    // [0] beat_found
);

    uop_t       op;
    efbr_cond_t cond;

    logic signed [LOW_W-1:0]   threshold_reg, threshold_next;
    logic [CNT_W-1:0]          refractory_reg, refractory_next;
    logic [CNT_W-1:0]          numerator_reg, numerator_next;

    logic [SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [SAMPLE_W-1:0]       ring_reg [AVG_LEN], ring_next [AVG_LEN];
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [SAMPLE_W-1:0]       mean_reg, mean_next;
    logic [SAMPLE_W-1:0]       mhist_reg [TAPS], mhist_next [TAPS];
    logic signed [NOTCH_W-1:0] notch_reg, notch_next;
    logic signed [NOTCH_W-1:0] nhist_reg [TAPS], nhist_next [TAPS];
    logic signed [LOW_W-1:0]   low_reg, low_next;
    logic [CNT_W-1:0]          since_reg, since_next;
    logic [CNT_W-1:0]          rate_reg, rate_next;
    logic                      beat_reg, beat_next;

    logic [CNT_W-1:0]          rem_reg, rem_next;
    logic [CNT_W-1:0]          quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]      dcnt_reg, dcnt_next;

    logic                      out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]      out_data_reg, out_data_next;
    logic                      out_beat_reg, out_beat_next;

    logic signed [LOW_W-1:0]   n_cur, n0, n1, n2, n3, low_sum;
    logic [CNT_W:0]            trial, shifted;
    logic                      beat_now;

    efbr_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .op      (op)
    );

    assign beat_now = (low_reg > threshold_reg) && (since_reg > refractory_reg);

    assign cond = '{in_valid: s_tvalid,
                    beat:     beat_now,
                    div_last: (dcnt_reg == DIV_CNT_W'(CNT_W - 1)),
                    out_free: (!out_valid_reg || m_tready)};

    assign s_tready = (op == OP_LOAD);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_beat_reg;

    assign n_cur = LOW_W'(notch_reg);
    assign n0    = LOW_W'(nhist_reg[0]);
    assign n1    = LOW_W'(nhist_reg[1]);
    assign n2    = LOW_W'(nhist_reg[2]);
    assign n3    = LOW_W'(nhist_reg[3]);
    assign low_sum = n_cur + (n0 <<< 2) + (n1 <<< 2) + (n1 <<< 1) + (n2 <<< 2) + n3;

    assign shifted = {rem_reg, quo_reg[CNT_W-1]};
    assign trial   = shifted - {1'b0, since_reg};

    always_comb begin
        threshold_next  = threshold_reg;
        refractory_next = refractory_reg;
        numerator_next  = numerator_reg;
        sample_next     = sample_reg;
        ring_next       = ring_reg;
        slot_next       = slot_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        mhist_next      = mhist_reg;
        notch_next      = notch_reg;
        nhist_next      = nhist_reg;
        low_next        = low_reg;
        since_next      = since_reg;
        rate_next       = rate_reg;
        beat_next       = beat_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dcnt_next       = dcnt_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_beat_next   = out_beat_reg;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_THRESHOLD:  threshold_next  = cfg_wdata[LOW_W-1:0];
                REG_REFRACTORY: refractory_next = cfg_wdata;
                REG_NUMERATOR:  numerator_next  = cfg_wdata;
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (op)
            OP_LOAD: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                end
            end
            OP_RING: begin
                sum_next            = sum_reg - SUM_W'(ring_reg[slot_reg]) + SUM_W'(sample_reg);
                ring_next[slot_reg] = sample_reg;
                slot_next           = slot_reg + 1'b1;
            end
            OP_NOTCH: begin
                mean_next  = sum_reg[SUM_W-1:AVG_LOG2];
                notch_next = $signed({1'b0, sum_reg[SUM_W-1:AVG_LOG2]})
                           - $signed({1'b0, mhist_reg[TAPS-1]});
            end
            OP_LOW: begin
                low_next = low_sum;
                for (int i = TAPS - 1; i > 0; i--) begin
                    mhist_next[i] = mhist_reg[i-1];
                    nhist_next[i] = nhist_reg[i-1];
                end
                mhist_next[0] = mean_reg;
                nhist_next[0] = notch_reg;
            end
            OP_TEST: begin
                beat_next = beat_now;
                rem_next  = '0;
                quo_next  = numerator_reg;
                dcnt_next = '0;
                if (!beat_now && since_reg != COUNT_MAX) begin
                    since_next = since_reg + 1'b1;
                end
            end
            OP_DIV: begin
                if (!trial[CNT_W]) begin
                    rem_next = trial[CNT_W-1:0];
                    quo_next = {quo_reg[CNT_W-2:0], 1'b1};
                end else begin
                    rem_next = shifted[CNT_W-1:0];
                    quo_next = {quo_reg[CNT_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (cond.div_last) begin
                    rate_next  = quo_next;
                    since_next = '0;
                end
            end
            OP_EMIT: begin
                if (cond.out_free) begin
                    out_valid_next = 1'b1;
                    out_beat_next  = beat_reg;
                    out_data_next  = {7'd0, rate_reg, low_reg, mean_reg};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RST;
            refractory_reg <= REFRACTORY_RST;
            numerator_reg  <= NUMERATOR_RST;
            for (int i = 0; i < AVG_LEN; i++) begin
                ring_reg[i] <= '0;
            end
            for (int i = 0; i < TAPS; i++) begin
                mhist_reg[i] <= '0;
                nhist_reg[i] <= '0;
            end
            slot_reg      <= '0;
            sum_reg       <= '0;
            since_reg     <= '0;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            threshold_reg  <= threshold_next;
            refractory_reg <= refractory_next;
            numerator_reg  <= numerator_next;
            ring_reg       <= ring_next;
            mhist_reg      <= mhist_next;
            nhist_reg      <= nhist_next;
            slot_reg       <= slot_next;
            sum_reg        <= sum_next;
            since_reg      <= since_next;
            rate_reg       <= rate_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        mean_reg     <= mean_next;
        notch_reg    <= notch_next;
        low_reg      <= low_next;
        beat_reg     <= beat_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        out_data_reg <= out_data_next;
        out_beat_reg <= out_beat_next;
    end

endmodule
